// ===== design/assert_macros.svh =====
// assertion helpers used by the checker file ssd_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== design/ssd_pkg.sv =====
package ssd_pkg;

  localparam int unsigned NumDigits = 4;
  localparam int unsigned SlotIdxW  = 2;
  localparam int unsigned BitCntW   = 6;
  localparam int unsigned ValueW    = 14;

  localparam logic [2:0] OpLoad   = 3'd0;
  localparam logic [2:0] OpWrite  = 3'd1;
  localparam logic [2:0] OpClear  = 3'd2;
  localparam logic [2:0] OpZeros  = 3'd3;
  localparam logic [2:0] OpScan   = 3'd4;

  localparam logic [7:0] BlankCode = 8'hFF;
  localparam logic [7:0] ZeroCode  = 8'hC0;
  localparam logic [ValueW-1:0] MaxValue = ValueW'(9999);

  // decimal places worked through by the load sequence
  localparam logic [1:0] PlThousands = 2'd0;
  localparam logic [1:0] PlHundreds  = 2'd1;
  localparam logic [1:0] PlTens      = 2'd2;

  typedef struct packed {
    logic load_start;
    logic load_step;
    logic write_digit;
    logic clear;
    logic show_zeros;
    logic scan_start;
    logic scan_step;
  } ssd_cmd_t;

  typedef struct packed {
    logic load_done;
    logic scan_done;
  } ssd_sts_t;

  function automatic logic [7:0] encode_digit(input logic [3:0] d);
    logic [7:0] code;
    case (d)
      4'd0:    code = 8'hC0;
      4'd1:    code = 8'hF9;
      4'd2:    code = 8'hA4;
      4'd3:    code = 8'hB0;
      4'd4:    code = 8'h99;
      4'd5:    code = 8'h92;
      4'd6:    code = 8'h82;
      4'd7:    code = 8'hF8;
      4'd8:    code = 8'h80;
      4'd9:    code = 8'h90;
      default: code = BlankCode;
    endcase
    return code;
  endfunction

  function automatic logic [ValueW-1:0] place_value(input logic [1:0] pl);
    logic [ValueW-1:0] v;
    case (pl)
      PlThousands: v = ValueW'(1000);
      PlHundreds:  v = ValueW'(100);
      default:     v = ValueW'(10);
    endcase
    return v;
  endfunction

  // display slot of each place: thousands in slot 1, hundreds in slot 0, tens in slot 3
  function automatic logic [SlotIdxW-1:0] place_slot(input logic [1:0] pl);
    logic [SlotIdxW-1:0] s;
    case (pl)
      PlThousands: s = SlotIdxW'(1);
      PlHundreds:  s = SlotIdxW'(0);
      default:     s = SlotIdxW'(3);
    endcase
    return s;
  endfunction

endpackage

// ===== design/ssd_ctrl.sv =====
module ssd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        opcode_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ssd_pkg::ssd_cmd_t cmd_o,
  input  ssd_pkg::ssd_sts_t sts_i
);

  typedef enum logic [1:0] {
    StIdle,
    StLoad,
    StScan
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_accept;

  assign in_stall_o  = (state_q != StIdle);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q;
    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          unique case (opcode_i)
            ssd_pkg::OpLoad: begin
              cmd_o.load_start = 1'b1;
              state_d          = StLoad;
            end
            ssd_pkg::OpWrite: cmd_o.write_digit = 1'b1;
            ssd_pkg::OpClear: cmd_o.clear = 1'b1;
            ssd_pkg::OpZeros: cmd_o.show_zeros = 1'b1;
            ssd_pkg::OpScan: begin
              cmd_o.scan_start = 1'b1;
              state_d          = StScan;
              out_valid_d      = 1'b1;
            end
            default: ;
          endcase
        end
      end
      StLoad: begin
        cmd_o.load_step = 1'b1;
        if (sts_i.load_done) begin
          state_d = StIdle;
        end
      end
      StScan: begin
        if (!out_stall_i) begin
          cmd_o.scan_step = 1'b1;
          if (sts_i.scan_done) begin
            state_d     = StIdle;
            out_valid_d = 1'b0;
          end
        end
      end
      default: begin
        state_d     = StIdle;
        out_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== design/ssd_dpath.sv =====
module ssd_dpath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ssd_pkg::ssd_cmd_t          cmd_i,
  output ssd_pkg::ssd_sts_t          sts_o,
  input  logic [ssd_pkg::ValueW-1:0] value_i,
  input  logic [1:0]                 position_i,
  input  logic [3:0]                 digit_i,
  output logic                       serial_data_o,
  output logic                       latch_pulse_o,
  output logic                       last_o
);

  logic [7:0]                  slots_q [ssd_pkg::NumDigits];
  logic [7:0]                  slots_d [ssd_pkg::NumDigits];
  logic [ssd_pkg::ValueW-1:0]  rem_q, rem_d;
  logic [ssd_pkg::ValueW-1:0]  place;
  logic [3:0]                  cnt_q, cnt_d;
  logic [1:0]                  pl_q, pl_d;
  logic [ssd_pkg::BitCntW-1:0] bit_q, bit_d;
  logic                        rem_ge;
  logic [ssd_pkg::SlotIdxW-1:0] scan_slot;
  logic [7:0]                  scan_byte;

  assign place  = ssd_pkg::place_value(pl_q);
  assign rem_ge = (rem_q >= place);

  assign sts_o.load_done = (pl_q == ssd_pkg::PlTens) && !rem_ge;
  assign sts_o.scan_done = (bit_q == {ssd_pkg::BitCntW{1'b1}});

  always_comb begin
    slots_d = slots_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    pl_d    = pl_q;
    bit_d   = bit_q;

    if (cmd_i.load_start) begin
      rem_d = (value_i > ssd_pkg::MaxValue) ? ssd_pkg::MaxValue : value_i;
      cnt_d = '0;
      pl_d  = ssd_pkg::PlThousands;
    end

    // one subtraction of the current place per cycle
    if (cmd_i.load_step) begin
      if (rem_ge) begin
        rem_d = rem_q - place;
        cnt_d = cnt_q + 4'd1;
      end else begin
        slots_d[ssd_pkg::place_slot(pl_q)] = ssd_pkg::encode_digit(cnt_q);
        cnt_d = '0;
        if (pl_q == ssd_pkg::PlTens) begin
          slots_d[2] = ssd_pkg::encode_digit(rem_q[3:0]);
        end else begin
          pl_d = pl_q + 2'd1;
        end
      end
    end

    if (cmd_i.write_digit) begin
      slots_d[position_i] = ssd_pkg::encode_digit(digit_i);
    end

    if (cmd_i.clear) begin
      for (int i = 0; i < ssd_pkg::NumDigits; i++) begin
        slots_d[i] = ssd_pkg::BlankCode;
      end
    end

    // leading zero cascade 3, 2, 1
    if (cmd_i.show_zeros && slots_q[3] == ssd_pkg::BlankCode) begin
      slots_d[3] = ssd_pkg::ZeroCode;
      if (slots_q[2] == ssd_pkg::BlankCode) begin
        slots_d[2] = ssd_pkg::ZeroCode;
        if (slots_q[1] == ssd_pkg::BlankCode) begin
          slots_d[1] = ssd_pkg::ZeroCode;
        end
      end
    end

    if (cmd_i.scan_start) begin
      bit_d = '0;
    end else if (cmd_i.scan_step) begin
      bit_d = bit_q + ssd_pkg::BitCntW'(1);
    end
  end

  // beat layout: slot, then segment or select byte, then bit msb first
  assign scan_slot     = bit_q[5:4];
  assign scan_byte     = bit_q[3] ? (8'd1 << scan_slot) : slots_q[scan_slot];
  assign serial_data_o = scan_byte[3'd7 - bit_q[2:0]];
  assign latch_pulse_o = (bit_q[3:0] == 4'hF);
  assign last_o        = sts_o.scan_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ssd_pkg::NumDigits; i++) begin
        slots_q[i] <= ssd_pkg::BlankCode;
      end
      bit_q <= '0;
      pl_q  <= ssd_pkg::PlThousands;
    end else begin
      slots_q <= slots_d;
      bit_q   <= bit_d;
      pl_q    <= pl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    cnt_q <= cnt_d;
  end

endmodule

// ===== design/serial_seven_segment_scan_driver_unit.sv =====
// Four-slot seven-segment driver for a chain of two 8-bit shift registers.
// Commands are taken one at a time; in_stall_o is high while one is in work.
// Write digit, clear and show zeros complete in the cycle they are accepted.
// Load value splits the number by repeated subtraction of 1000, 100 and 10,
// one subtraction per cycle, and keeps the input stalled until the tens and
// units digits are stored. Refresh yields 64 output beats, one per cycle
// while out_stall_i is low: for each slot 0 to 3 the segment byte and then
// the one-hot select byte, msb first, with latch_pulse_o on the 16th beat of
// each slot and last_o on the 64th.
module serial_seven_segment_scan_driver_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [2:0]                 opcode_i,
  input  logic [ssd_pkg::ValueW-1:0] value_i,
  input  logic [1:0]                 position_i,
  input  logic [3:0]                 digit_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       serial_data_o,
  output logic                       latch_pulse_o,
  output logic                       last_o
);

  ssd_pkg::ssd_cmd_t cmd;
  ssd_pkg::ssd_sts_t sts;

  ssd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  ssd_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .value_i       (value_i),
    .position_i    (position_i),
    .digit_i       (digit_i),
    .serial_data_o (serial_data_o),
    .latch_pulse_o (latch_pulse_o),
    .last_o        (last_o)
  );

endmodule

// ===== design/ssd_checker.sv =====
`include "assert_macros.svh"

module ssd_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic latch_pulse_o,
  input logic last_o
);

  logic out_beat;
  logic in_open;
  logic last_shown;
  logic last_beat;
  logic mid_latch;
  logic in_gap;

  assign out_beat   = out_valid_o && !out_stall_i;
  assign in_open    = !in_stall_o;
  assign last_shown = out_valid_o && last_o;
  assign last_beat  = out_beat && last_o;
  assign mid_latch  = out_beat && latch_pulse_o && !last_o;
  assign in_gap     = out_valid_o && !latch_pulse_o;

  // no new command while a refresh is still going out
  `ASSERT_NEVER(a_no_cmd_in_scan, clk_i, rst_ni, out_valid_o && in_open, "command taken in refresh")

  `ASSERT_PROP(a_last_latches, clk_i, rst_ni, last_shown |-> latch_pulse_o, "last beat not latched")

  `ASSERT_PROP(a_scan_ends, clk_i, rst_ni, last_beat |=> !out_valid_o, "refresh overruns")

  `ASSERT_PROP(a_latch_spacing, clk_i, rst_ni, mid_latch |=> in_gap, "latch beats not apart")

endmodule

bind serial_seven_segment_scan_driver_unit ssd_checker u_ssd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .latch_pulse_o (latch_pulse_o),
  .last_o        (last_o)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam logic [2:0] OpUnusedLo = 3'd5;
  localparam logic [2:0] OpUnusedHi = 3'd7;
  localparam logic [ssd_pkg::ValueW-1:0] ValueAllOnes = {ssd_pkg::ValueW{1'b1}};
  localparam logic [79:0] SegLut = {8'h90, 8'h80, 8'hF8, 8'h82, 8'h92,
                                    8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0};
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned TailCycles = 100;

  typedef struct packed {
    logic data;
    logic latch;
    logic last;
  } scan_beat_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic [2:0]                 opcode_i;
  logic [ssd_pkg::ValueW-1:0] value_i;
  logic [1:0]                 position_i;
  logic [3:0]                 digit_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic                       serial_data_o;
  logic                       latch_pulse_o;
  logic                       last_o;

  logic [7:0]  disp_slots [ssd_pkg::NumDigits];
  scan_beat_t  expected_beats_q [$];
  int unsigned fail_cnt    = 0;
  int unsigned cmd_cnt     = 0;
  int unsigned scan_cnt    = 0;
  int unsigned beat_cnt    = 0;
  int unsigned cycle_cnt   = 0;
  int unsigned stall_pct   = 0;
  int unsigned stall_left  = 0;

  serial_seven_segment_scan_driver_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .value_i       (value_i),
    .position_i    (position_i),
    .digit_i       (digit_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .serial_data_o (serial_data_o),
    .latch_pulse_o (latch_pulse_o),
    .last_o        (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [7:0] seg_code(input int unsigned d);
    if (d > 9) begin
      return ssd_pkg::BlankCode;
    end
    return SegLut[d*8 +: 8];
  endfunction

  function automatic void predict_command(input logic [2:0] op,
                                          input logic [ssd_pkg::ValueW-1:0] val,
                                          input logic [1:0] pos, input logic [3:0] dig);
    int unsigned v;
    logic [7:0]  sel;
    scan_beat_t  b;
    v = (val > ssd_pkg::MaxValue) ? ssd_pkg::MaxValue : val;
    case (op)
      ssd_pkg::OpLoad: begin
        disp_slots[1] = seg_code(v / 1000);
        disp_slots[0] = seg_code((v % 1000) / 100);
        disp_slots[3] = seg_code((v % 100) / 10);
        disp_slots[2] = seg_code(v % 10);
      end
      ssd_pkg::OpWrite: begin
        disp_slots[pos] = seg_code(dig);
      end
      ssd_pkg::OpClear: begin
        for (int k = 0; k < ssd_pkg::NumDigits; k++) disp_slots[k] = ssd_pkg::BlankCode;
      end
      ssd_pkg::OpZeros: begin
        if (disp_slots[3] == ssd_pkg::BlankCode) begin
          disp_slots[3] = ssd_pkg::ZeroCode;
          if (disp_slots[2] == ssd_pkg::BlankCode) begin
            disp_slots[2] = ssd_pkg::ZeroCode;
            if (disp_slots[1] == ssd_pkg::BlankCode) disp_slots[1] = ssd_pkg::ZeroCode;
          end
        end
      end
      ssd_pkg::OpScan: begin
        for (int k = 0; k < ssd_pkg::NumDigits; k++) begin
          sel = 8'(1 << k);
          for (int i = 7; i >= 0; i--) begin
            b.data  = disp_slots[k][i];
            b.latch = 1'b0;
            b.last  = 1'b0;
            expected_beats_q.push_back(b);
          end
          for (int i = 7; i >= 0; i--) begin
            b.data  = sel[i];
            b.latch = (i == 0);
            b.last  = (i == 0) && (k == ssd_pkg::NumDigits - 1);
            expected_beats_q.push_back(b);
          end
        end
        scan_cnt++;
      end
      default: begin
      end
    endcase
  endfunction

  // command acceptance and serial beat checking
  always @(posedge clk_i) begin : mon
    scan_beat_t exp_b;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_command(opcode_i, value_i, position_i, digit_i);
        cmd_cnt++;
      end
      if (out_valid_o && !out_stall_i) begin
        beat_cnt++;
        if (expected_beats_q.size() == 0) begin
          $error("unexpected beat: serial_data %0b latch_pulse %0b last %0b",
                 serial_data_o, latch_pulse_o, last_o);
          fail_cnt++;
        end else begin
          exp_b = expected_beats_q.pop_front();
          if (serial_data_o !== exp_b.data) begin
            $error("serial_data expected %0b actual %0b", exp_b.data, serial_data_o);
            fail_cnt++;
          end
          if (latch_pulse_o !== exp_b.latch) begin
            $error("latch_pulse expected %0b actual %0b", exp_b.latch, latch_pulse_o);
            fail_cnt++;
          end
          if (last_o !== exp_b.last) begin
            $error("last expected %0b actual %0b", exp_b.last, last_o);
            fail_cnt++;
          end
        end
      end
    end
  end

  // receiver stall pattern in runs of random length
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(1, 12);
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end else begin
      stall_left--;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("serial_seven_segment_scan_driver_unit: mismatch");
      $finish;
    end
  end

  task automatic send_command(input logic [2:0] op, input logic [ssd_pkg::ValueW-1:0] val,
                              input logic [1:0] pos, input logic [3:0] dig);
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    value_i    <= val;
    position_i <= pos;
    digit_i    <= dig;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic idle_gap(input int unsigned n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_beats_q.size() != 0);
  endtask

  task automatic test_reset_scan();
    send_command(ssd_pkg::OpScan, '0, '0, '0);
  endtask

  task automatic test_load_extremes();
    send_command(ssd_pkg::OpLoad, '0, 2'd3, 4'd15);
    send_command(ssd_pkg::OpScan, '0, '0, '0);
    send_command(ssd_pkg::OpLoad, ssd_pkg::MaxValue, '0, '0);
    send_command(ssd_pkg::OpScan, ValueAllOnes, 2'd3, 4'd15);
    // out of range value saturates
    send_command(ssd_pkg::OpLoad, ValueAllOnes, '0, '0);
    send_command(ssd_pkg::OpScan, '0, '0, '0);
  endtask

  task automatic test_write_digit();
    send_command(ssd_pkg::OpWrite, ValueAllOnes, 2'd0, 4'd0);
    send_command(ssd_pkg::OpWrite, '0, 2'd1, 4'd9);
    send_command(ssd_pkg::OpWrite, '0, 2'd2, 4'd15);
    send_command(ssd_pkg::OpWrite, '0, 2'd3, 4'd10);
    send_command(ssd_pkg::OpScan, '0, '0, '0);
  endtask

  task automatic test_clear_zeros();
    send_command(ssd_pkg::OpClear, ValueAllOnes, 2'd3, 4'd15);
    send_command(ssd_pkg::OpZeros, '0, '0, '0);
    send_command(ssd_pkg::OpScan, '0, '0, '0);
    // tens blank, units not: cascade stops after slot 3
    send_command(ssd_pkg::OpWrite, '0, 2'd3, 4'd15);
    send_command(ssd_pkg::OpZeros, '0, '0, '0);
    send_command(ssd_pkg::OpScan, '0, '0, '0);
    // slot 3 filled: nothing changes
    send_command(ssd_pkg::OpZeros, '0, '0, '0);
    send_command(ssd_pkg::OpScan, '0, '0, '0);
  endtask

  task automatic test_unknown_opcodes();
    for (int op = OpUnusedLo; op <= OpUnusedHi; op++) begin
      send_command(3'(op), ValueAllOnes, 2'd3, 4'd15);
    end
    send_command(ssd_pkg::OpScan, '0, '0, '0);
  endtask

  task automatic test_random(input int unsigned n_items, input int unsigned pct,
                             input bit gaps_on);
    int unsigned sent;
    int unsigned burst;
    int unsigned r;
    logic [2:0]                 op;
    logic [ssd_pkg::ValueW-1:0] val;
    logic [3:0]                 dig;
    sent      = 0;
    stall_pct = pct;
    while (sent < n_items) begin
      burst = $urandom_range(1, 8);
      for (int i = 0; i < burst && sent < n_items; i++) begin
        r = $urandom_range(0, 99);
        if (r < 25)      op = ssd_pkg::OpLoad;
        else if (r < 45) op = ssd_pkg::OpWrite;
        else if (r < 52) op = ssd_pkg::OpClear;
        else if (r < 62) op = ssd_pkg::OpZeros;
        else if (r < 92) op = ssd_pkg::OpScan;
        else             op = 3'($urandom_range(OpUnusedLo, OpUnusedHi));
        if ($urandom_range(0, 9) == 0) begin
          val = ssd_pkg::ValueW'($urandom_range(ssd_pkg::MaxValue + 1, ValueAllOnes));
        end else begin
          val = ssd_pkg::ValueW'($urandom_range(0, ssd_pkg::MaxValue));
        end
        if ($urandom_range(0, 4) == 0) dig = 4'($urandom_range(10, 15));
        else                          dig = 4'($urandom_range(0, 9));
        send_command(op, val, 2'($urandom_range(0, 3)), dig);
        sent++;
      end
      if ($urandom_range(0, 7) == 0) wait_drained();
      else if (gaps_on)              idle_gap($urandom_range(1, 6));
    end
    wait_drained();
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    opcode_i    = '0;
    value_i     = '0;
    position_i  = '0;
    digit_i     = '0;
    out_stall_i = 1'b0;
    for (int k = 0; k < ssd_pkg::NumDigits; k++) disp_slots[k] = ssd_pkg::BlankCode;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_scan();
    test_load_extremes();
    test_write_digit();
    test_clear_zeros();
    test_unknown_opcodes();
    wait_drained();
    test_random(45, 30, 1'b1);
    test_random(35, 75, 1'b1);
    test_random(30, 0, 1'b0);

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (expected_beats_q.size() != 0) begin
      $error("%0d expected beats never arrived", expected_beats_q.size());
      fail_cnt++;
    end
    $display("run covered %0d commands, %0d refresh scans and %0d serial beats",
             cmd_cnt, scan_cnt, beat_cnt);
    $display("with sender bursts and gaps, receiver stalls from none to heavy");
    if (fail_cnt == 0) begin
      $display("serial_seven_segment_scan_driver_unit: match");
    end else begin
      $display("serial_seven_segment_scan_driver_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/ssd_pkg.sv
design/ssd_ctrl.sv
design/ssd_dpath.sv
design/serial_seven_segment_scan_driver_unit.sv
design/ssd_checker.sv
dv/tb_top.sv
